### design/nobap_pkg.sv
// package for the noc output buffer with ack priority
// shared command, kind and mode codes and depth defaults; no dependencies
`default_nettype none
package nobap_pkg;
  localparam int FLIT_DEPTH_DEF = 64;
  localparam int ACK_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    CMD_FLIT = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_NACK = 2'd2,
    CMD_POP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_FLIT = 2'd1,
    KIND_ACK  = 2'd2,
    KIND_NACK = 2'd3
  } kind_t;

  localparam logic [1:0] MODE_BLOCK    = 2'd0;
  localparam logic [1:0] MODE_PRESERVE = 2'd1;
  localparam logic [1:0] MODE_DISCARD  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] pkt_id;
    logic        is_head;
    logic        is_tail;
    logic [31:0] payload;
  } cmd_word_t;

  typedef struct packed {
    logic        both_idle;
    logic        push_dropped;
    logic        overflow;
    logic [1:0]  kind;
    logic [15:0] pkt_id;
    logic        is_head;
    logic        is_tail;
    logic [31:0] payload;
    logic        packet_ended;
    logic        flit_discarded;
  } res_word_t;
endpackage
`default_nettype wire

### design/nobap_cmd_queue.sv
// front part: two-entry command queue between port and engine
// depends on nobap_pkg
`default_nettype none
module nobap_cmd_queue
  import nobap_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_en,
  input  wire cmd_word_t wr_data,
  output logic           full,
  output logic           avail,
  input  wire logic      rd_en,
  output cmd_word_t      rd_data
);
  cmd_word_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = cnt_r == 2'd2;
  assign avail   = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) full |-> !wr_en)
    else $error("write into full command queue");
  assert property (@(posedge clk) disable iff (!rst_n) !avail |-> !rd_en)
    else $error("read from empty command queue");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("command queue count out of range");
endmodule
`default_nettype wire

### design/nobap_engine.sv
// back part: flit and ack fifos, dedup scan, pop arbitration, result register
// depends on nobap_pkg
`default_nettype none
module nobap_engine
  import nobap_pkg::*;
#(
  parameter int FLIT_DEPTH = FLIT_DEPTH_DEF,
  parameter int ACK_DEPTH  = ACK_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic [1:0] pop_mode,
  input  wire logic      cmd_avail,
  input  wire cmd_word_t cmd,
  output logic           cmd_take,
  output logic           res_valid,
  output res_word_t      res,
  input  wire logic      res_take
);
  localparam int FW = (FLIT_DEPTH > 1) ? $clog2(FLIT_DEPTH) : 1;
  localparam int AW = (ACK_DEPTH > 1) ? $clog2(ACK_DEPTH) : 1;
  localparam int FCW = $clog2(FLIT_DEPTH + 1);
  localparam int ACW = $clog2(ACK_DEPTH + 1);

  typedef struct packed {
    logic [15:0] id;
    logic        head;
    logic        tail;
    logic [31:0] payload;
  } flit_t;
  typedef struct packed {
    logic [15:0] id;
    logic        nack;
  } ack_t;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DISC, S_READ, S_DONE} state_t;

  flit_t fmem [FLIT_DEPTH];
  ack_t  amem [ACK_DEPTH];
  flit_t fq_r;
  ack_t  aq_r;
  logic [FW-1:0]  frp_r;
  logic [FCW-1:0] fcnt_r;
  logic [AW-1:0]  arp_r;
  logic [ACW-1:0] acnt_r;
  logic           intx_r;
  state_t         st_r;
  cmd_word_t      c_r;
  logic [ACW-1:0] si_r;
  logic           sack_r;
  res_word_t      res_r;
  logic           rv_r;

  logic [FW-1:0] fwa, fra;
  logic [AW-1:0] awa, ara;
  logic          fwe, awe;
  logic [FW:0]   fsum;
  logic [AW:0]   asum;
  logic          scan_hit;
  res_word_t     res_init;

  always_comb begin
    fsum = {1'b0, frp_r} + FW'(fcnt_r);
    asum = {1'b0, arp_r} + AW'(acnt_r);
    if (FLIT_DEPTH == (1 << FW)) fwa = fsum[FW-1:0];
    else fwa = (fsum >= (FW+1)'(FLIT_DEPTH)) ? FW'(fsum - (FW+1)'(FLIT_DEPTH)) : fsum[FW-1:0];
    if (ACK_DEPTH == (1 << AW) && ACK_DEPTH > 1) awa = asum[AW-1:0];
    else if (ACK_DEPTH == 1) awa = '0;
    else awa = (asum >= (AW+1)'(ACK_DEPTH)) ? AW'(asum - (AW+1)'(ACK_DEPTH)) : asum[AW-1:0];
    fra = frp_r;
    ara = arp_r;
    if (st_r == S_SCAN) begin
      asum = {1'b0, arp_r} + AW'(si_r);
      if (ACK_DEPTH == 1) ara = '0;
      else if (ACK_DEPTH == (1 << AW)) ara = asum[AW-1:0];
      else ara = (asum >= (AW+1)'(ACK_DEPTH)) ? AW'(asum - (AW+1)'(ACK_DEPTH)) : asum[AW-1:0];
    end
    // aq_r holds the entry one behind the scan index
    scan_hit = st_r == S_SCAN && si_r != '0 && aq_r.id == c_r.pkt_id
               && aq_r.nack == (c_r.command == CMD_NACK);
    res_init = '0;
    res_init.both_idle = cmd.command != CMD_POP && fcnt_r == '0 && acnt_r == '0;
    if (cmd.command == CMD_FLIT && fcnt_r >= FCW'(FLIT_DEPTH)) begin
      res_init.push_dropped = 1'b1;
      res_init.overflow     = 1'b1;
    end
    fwe = 1'b0;
    awe = 1'b0;
    if (st_r == S_IDLE && cmd_avail && !rv_r && cmd.command == CMD_FLIT
        && fcnt_r < FCW'(FLIT_DEPTH)) fwe = 1'b1;
    if (st_r == S_SCAN && (si_r >= acnt_r) && !scan_hit && acnt_r < ACW'(ACK_DEPTH))
      awe = 1'b1;
  end

  function automatic logic [FW-1:0] finc(logic [FW-1:0] p);
    if (FLIT_DEPTH == (1 << FW)) return p + 1'b1;
    return (p == FW'(FLIT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction
  function automatic logic [AW-1:0] ainc(logic [AW-1:0] p);
    if (ACK_DEPTH == 1) return '0;
    if (ACK_DEPTH == (1 << AW)) return p + 1'b1;
    return (p == AW'(ACK_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (fwe) fmem[fwa] <= '{cmd.pkt_id, cmd.is_head, cmd.is_tail, cmd.payload};
    if (awe) amem[awa] <= '{c_r.pkt_id, c_r.command == CMD_NACK};
    fq_r <= fmem[fra];
    aq_r <= amem[ara];
  end

  assign cmd_take  = st_r == S_IDLE && cmd_avail && !rv_r;
  assign res_valid = rv_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      frp_r  <= '0;
      fcnt_r <= '0;
      arp_r  <= '0;
      acnt_r <= '0;
      intx_r <= 1'b0;
      rv_r   <= 1'b0;
    end else begin
      if (rv_r && res_take) rv_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (cmd_take) begin
            c_r   <= cmd;
            res_r <= res_init;
            si_r  <= '0;
            case (cmd.command)
              CMD_FLIT: begin
                if (fcnt_r < FCW'(FLIT_DEPTH)) fcnt_r <= fcnt_r + 1'b1;
                rv_r <= 1'b1;
              end
              CMD_ACK, CMD_NACK: begin
                st_r <= S_SCAN;
              end
              default: begin
                if (pop_mode == MODE_PRESERVE) sack_r <= acnt_r != '0;
                else if (pop_mode == MODE_DISCARD) sack_r <= acnt_r != '0;
                else sack_r <= acnt_r != '0 && !intx_r;
                st_r <= (pop_mode == MODE_DISCARD && acnt_r != '0 && intx_r
                         && fcnt_r != '0) ? S_DISC : S_READ;
              end
            endcase
          end
        end
        S_SCAN: begin
          // one entry compared per cycle; last step writes or drops
          if (scan_hit) begin
            res_r.push_dropped <= 1'b1;
            rv_r <= 1'b1;
            st_r <= S_IDLE;
          end else if (si_r >= acnt_r) begin
            if (acnt_r >= ACW'(ACK_DEPTH)) begin
              res_r.push_dropped <= 1'b1;
              res_r.overflow     <= 1'b1;
            end else acnt_r <= acnt_r + 1'b1;
            rv_r <= 1'b1;
            st_r <= S_IDLE;
          end else si_r <= si_r + 1'b1;
        end
        S_DISC: begin
          frp_r  <= finc(frp_r);
          fcnt_r <= fcnt_r - 1'b1;
          res_r.flit_discarded <= 1'b1;
          if (fq_r.tail) begin
            intx_r <= 1'b0;
            res_r.packet_ended <= 1'b1;
          end
          st_r <= S_READ;
        end
        S_READ: st_r <= S_DONE;
        S_DONE: begin
          if (sack_r) begin
            arp_r  <= ainc(arp_r);
            acnt_r <= acnt_r - 1'b1;
            res_r.kind   <= aq_r.nack ? KIND_NACK : KIND_ACK;
            res_r.pkt_id <= aq_r.id;
          end else if (fcnt_r != '0) begin
            frp_r  <= finc(frp_r);
            fcnt_r <= fcnt_r - 1'b1;
            res_r.kind      <= KIND_FLIT;
            res_r.pkt_id    <= fq_r.id;
            res_r.is_head   <= fq_r.head;
            res_r.is_tail   <= fq_r.tail;
            res_r.payload   <= fq_r.payload;
            if (fq_r.tail) begin
              intx_r <= 1'b0;
              res_r.packet_ended <= 1'b1;
            end else if (fq_r.head) intx_r <= 1'b1;
          end
          rv_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) fcnt_r <= FCW'(FLIT_DEPTH))
    else $error("flit count beyond depth");
  assert property (@(posedge clk) disable iff (!rst_n) acnt_r <= ACW'(ACK_DEPTH))
    else $error("ack count beyond depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DISC |=> res_r.flit_discarded)
    else $error("discard not flagged");
  assert property (@(posedge clk) disable iff (!rst_n) rv_r |-> !cmd_take)
    else $error("command taken while result pending");
endmodule
`default_nettype wire

### design/noc_output_buffer_ack_priority.sv
// top level of the noc output buffer with ack priority
// depends on nobap_pkg, nobap_cmd_queue, nobap_engine
//
// input channel: push/full; commands push a flit, push an ack or nack, or pop.
// a two-entry command queue takes words while the engine works.
// result channel: empty/pop; one result word per command, in order.
// cfg channel: valid/ready, writes pop_mode; ready is always high.
// a flit push writes the flit fifo directly; an ack/nack push runs the dedup
// scan that compares one stored ack per cycle; a pop passes S_READ and S_DONE,
// after S_DISC when a flit is discarded, for the registered fifo memory read.
// a command is started only once the previous result has been popped, so a
// stalled receiver holds the engine and the command queue fills and raises full.
// reset clears counts, pointers, in-transmission flag and pop_mode; fifo
// contents are not cleared and need no clearing pass.
`default_nettype none
module noc_output_buffer_ack_priority
  import nobap_pkg::*;
#(
  parameter int FLIT_DEPTH = FLIT_DEPTH_DEF,
  parameter int ACK_DEPTH  = ACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_command,
  input  wire logic [15:0] in_pkt_id,
  input  wire logic        in_flit_is_head,
  input  wire logic        in_flit_is_tail,
  input  wire logic [31:0] in_flit_payload,
  output logic             empty,
  input  wire logic        pop,
  output logic             out_both_idle,
  output logic             out_push_dropped,
  output logic             out_overflow,
  output logic [1:0]       out_out_kind,
  output logic [15:0]      out_out_pkt_id,
  output logic             out_out_is_head,
  output logic             out_out_is_tail,
  output logic [31:0]      out_out_payload,
  output logic             out_packet_ended,
  output logic             out_flit_discarded,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_pop_mode
);
  logic [1:0] mode_r;
  cmd_word_t  qd;
  logic       avail, take, rv;
  res_word_t  rs;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= MODE_BLOCK;
    else if (cfg_valid) mode_r <= cfg_pop_mode;
  end

  nobap_cmd_queue u_q (
    .clk, .rst_n,
    .wr_en   (push && !full),
    .wr_data ('{in_command, in_pkt_id, in_flit_is_head, in_flit_is_tail,
                in_flit_payload}),
    .full,
    .avail,
    .rd_en   (take),
    .rd_data (qd)
  );

  nobap_engine #(.FLIT_DEPTH(FLIT_DEPTH), .ACK_DEPTH(ACK_DEPTH)) u_eng (
    .clk, .rst_n,
    .pop_mode  (mode_r),
    .cmd_avail (avail),
    .cmd       (qd),
    .cmd_take  (take),
    .res_valid (rv),
    .res       (rs),
    .res_take  (pop)
  );

  assign empty              = !rv;
  assign out_both_idle      = rs.both_idle;
  assign out_push_dropped   = rs.push_dropped;
  assign out_overflow       = rs.overflow;
  assign out_out_kind       = rs.kind;
  assign out_out_pkt_id     = rs.pkt_id;
  assign out_out_is_head    = rs.is_head;
  assign out_out_is_tail    = rs.is_tail;
  assign out_out_payload    = rs.payload;
  assign out_packet_ended   = rs.packet_ended;
  assign out_flit_discarded = rs.flit_discarded;
endmodule
`default_nettype wire
